[design/sfp_pkg.sv]
// shared types, constants and helpers for the sensor frame parser
package sfp_pkg;

    localparam int STORED_BYTES = 19;
    localparam int STORE_IDX_W  = $clog2(STORED_BYTES);
    localparam int PV_COUNT     = 6;
    localparam int VAL_W        = 17;

    localparam logic [7:0]  HDR_BYTE    = 8'hEF;
    localparam logic [7:0]  TRL_BYTE    = 8'hFE;
    localparam logic [7:0]  TYPE_PV     = 8'h0A;
    localparam logic [11:0] SILENCE_MAX = 12'hFFF;

    localparam logic [12:0] LOC_LIMIT_RST  = 13'd1000;
    localparam logic [12:0] VEL_LIMIT_RST  = 13'd100;
    localparam logic [11:0] TIMEOUT_RST    = 12'd100;
    localparam logic [11:0] LOST_RPT_RST   = 12'd1100;
    localparam logic [10:0] ERR_RPT_RST    = 11'd1000;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_PAYLOAD,
        PH_SUM,
        PH_TRAILER
    } phase_t;

    typedef enum logic [1:0] {
        ST_LOST,
        ST_WORKING,
        ST_OVER
    } status_t;

    typedef enum logic [2:0] {
        REG_LOC_LIMIT,
        REG_VEL_LIMIT,
        REG_TIMEOUT,
        REG_LOST_RPT,
        REG_ERR_RPT
    } reg_idx_t;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        logic [12:0] loc_limit;
        logic [12:0] vel_limit;
    } limit_cfg_t;

    typedef struct packed {
        logic [11:0] timeout_ms;
        logic [11:0] lost_report_ms;
        logic [10:0] error_report_ticks;
    } link_cfg_t;

    typedef struct packed {
        logic done;
        logic over_limit;
    } frame_evt_t;

    typedef struct packed {
        logic       valid;
        logic [9:0] ms;
    } tick_t;

    // sign byte nonzero means negative, x and y axes flip the sign
    function automatic val_t decode_val(input logic [7:0] sign_byte,
                                        input logic [15:0] mag,
                                        input logic flip);
        logic neg;
        val_t m;
        neg = (sign_byte != 8'd0) ^ flip;
        m   = val_t'({1'b0, mag});
        return neg ? -m : m;
    endfunction

    // trunc(mag / 10) > limit  <=>  mag > 10 * limit + 9
    function automatic logic over_limit(input logic [15:0] mag,
                                        input logic [12:0] limit);
        logic [16:0] thr;
        thr = {1'b0, limit, 3'b000} + {3'b000, limit, 1'b0} + 17'd9;
        return {1'b0, mag} > thr;
    endfunction

endpackage

[design/sfp_if.sv]
// request and response channel interfaces

interface sfp_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;
    logic [9:0] elapsed_ms;

    modport source (output valid, output req_type, output rx_byte, output elapsed_ms,
                    input ready);
    modport sink (input valid, input req_type, input rx_byte, input elapsed_ms,
                  output ready);
endinterface

interface sfp_rsp_if;
    logic              valid;
    logic              ready;
    logic              frame_done;
    sfp_pkg::val_t     loc_x;
    sfp_pkg::val_t     loc_y;
    sfp_pkg::val_t     loc_z;
    sfp_pkg::val_t     vel_x;
    sfp_pkg::val_t     vel_y;
    sfp_pkg::val_t     vel_z;
    logic [1:0]        link_status;
    logic              lost_alarm;
    logic              error_alarm;

    modport source (output valid, output frame_done, output loc_x, output loc_y,
                    output loc_z, output vel_x, output vel_y, output vel_z,
                    output link_status, output lost_alarm, output error_alarm,
                    input ready);
    modport sink (input valid, input frame_done, input loc_x, input loc_y,
                  input loc_z, input vel_x, input vel_y, input vel_z,
                  input link_status, input lost_alarm, input error_alarm,
                  output ready);
endinterface

[design/sfp_parser.sv]
// byte-level frame parser, payload store and position/velocity decode
module sfp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  sfp_pkg::limit_cfg_t lim,
    output sfp_pkg::frame_evt_t evt,
    output sfp_pkg::val_t       pv [sfp_pkg::PV_COUNT]
);
    import sfp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] taken_reg, taken_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] store_reg [STORED_BYTES];
    val_t       pv_reg [PV_COUNT];
    val_t       pv_dec [PV_COUNT];
    logic       store_we;
    logic       frame_ok;
    logic [15:0] mag [PV_COUNT];

    always_comb
    begin
        for (int k = 0; k < PV_COUNT; k++)
        begin
            mag[k]    = {store_reg[2 + 3*k], store_reg[3 + 3*k]};
            pv_dec[k] = decode_val(store_reg[1 + 3*k], mag[k], (k % 3) != 2);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        frame_ok   = 1'b0;
        if (step)
        begin
            priority if (phase_reg == PH_HUNT && rx_byte == HDR_BYTE)
            begin
                len_next   = 8'd0;
                phase_next = PH_LEN;
            end
            else if (phase_reg == PH_LEN)
            begin
                len_next   = rx_byte;
                sum_next   = 8'd0;
                taken_next = 8'd0;
                phase_next = PH_PAYLOAD;
            end
            else if (phase_reg == PH_PAYLOAD && taken_reg < len_reg)
            begin
                store_we   = taken_reg < 8'(STORED_BYTES);
                taken_next = taken_reg + 8'd1;
                sum_next   = sum_reg + rx_byte;
                if (taken_next >= len_reg)
                    phase_next = PH_SUM;
            end
            else if (phase_reg == PH_SUM && rx_byte == sum_reg)
            begin
                phase_next = PH_TRAILER;
            end
            else if (phase_reg == PH_TRAILER && rx_byte == TRL_BYTE)
            begin
                frame_ok   = store_reg[0] == TYPE_PV;
                phase_next = PH_HUNT;
            end
            else
            begin
                phase_next = PH_HUNT;
            end
        end
    end

    assign evt.done       = frame_ok;
    assign evt.over_limit = over_limit(mag[0], lim.loc_limit) ||
                            over_limit(mag[1], lim.loc_limit) ||
                            over_limit(mag[3], lim.vel_limit) ||
                            over_limit(mag[4], lim.vel_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= 8'd0;
            taken_reg <= 8'd0;
            sum_reg   <= 8'd0;
            for (int i = 0; i < STORED_BYTES; i++)
                store_reg[i] <= 8'd0;
            for (int k = 0; k < PV_COUNT; k++)
                pv_reg[k] <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
            if (store_we)
                store_reg[taken_reg[STORE_IDX_W-1:0]] <= rx_byte;
            if (frame_ok)
            begin
                for (int k = 0; k < PV_COUNT; k++)
                    pv_reg[k] <= pv_dec[k];
            end
        end
    end

    assign pv = pv_reg;

endmodule

[design/sfp_link.sv]
// link status, silence timeout and alarm counters
module sfp_link (
    input  logic                clk,
    input  logic                rst_n,
    input  sfp_pkg::tick_t      tick,
    input  sfp_pkg::frame_evt_t evt,
    input  sfp_pkg::link_cfg_t  cfg,
    output sfp_pkg::status_t    status,
    output logic                lost,
    output logic                err
);
    import sfp_pkg::*;

    status_t     status_reg, status_next;
    logic [11:0] silence_reg, silence_next;
    logic [10:0] err_ticks_reg, err_ticks_next;
    logic [12:0] silence_sum;
    logic [11:0] silence_sat;

    assign silence_sum = {1'b0, silence_reg} + {3'b000, tick.ms};
    assign silence_sat = silence_sum[12] ? SILENCE_MAX : silence_sum[11:0];

    always_comb
    begin
        status_next    = status_reg;
        silence_next   = silence_reg;
        err_ticks_next = err_ticks_reg;
        lost           = 1'b0;
        err            = 1'b0;
        if (evt.done)
        begin
            silence_next = 12'd0;
            status_next  = evt.over_limit ? ST_OVER : ST_WORKING;
        end
        else if (tick.valid)
        begin
            silence_next = silence_sat;
            if (silence_sat >= cfg.timeout_ms)
            begin
                status_next = ST_LOST;
                if (silence_sat >= cfg.lost_report_ms)
                begin
                    silence_next = cfg.timeout_ms;
                    lost         = 1'b1;
                end
            end
            // error counting looks at status after the timeout check
            if (status_next == ST_OVER)
            begin
                if (err_ticks_reg >= cfg.error_report_ticks)
                begin
                    err            = 1'b1;
                    err_ticks_next = 11'd0;
                end
                else
                begin
                    err_ticks_next = err_ticks_reg + 11'd1;
                end
            end
            else
            begin
                err_ticks_next = 11'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= ST_LOST;
            silence_reg   <= 12'd0;
            err_ticks_reg <= 11'd0;
        end
        else
        begin
            status_reg    <= status_next;
            silence_reg   <= silence_next;
            err_ticks_reg <= err_ticks_next;
        end
    end

    assign status = status_reg;

endmodule

[design/sensor_frame_parser_with_timeout_unit.sv]
// a request beat passes the input register, then the result register, to become a response beat
// throughput one beat per cycle while responses are taken; parser and link state update in the cycle an item leaves
// the input register, and the response holds the updated state until taken
// a stalled response holds the input register; an empty input register still accepts one more beat
// reset (async, active low) clears parser and link state, payload store and values,
// and loads the limit, timeout and report registers with their defaults
module sensor_frame_parser_with_timeout_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sfp_req_if.sink     req,
    sfp_rsp_if.source   rsp
);
    import sfp_pkg::*;

    limit_cfg_t lim_reg;
    link_cfg_t  link_cfg_reg;
    logic       cfg_we;
    reg_idx_t   cfg_idx;

    logic       s1_valid_reg;
    logic       s1_type_reg;
    logic [7:0] s1_byte_reg;
    logic [9:0] s1_ms_reg;
    logic       advance;

    logic       out_valid_reg;
    logic       done_reg;
    logic       lost_reg;
    logic       err_reg;

    frame_evt_t evt;
    tick_t      tick;
    status_t    status;
    logic       lost;
    logic       err;
    val_t       pv [PV_COUNT];

    // configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.loc_limit               <= LOC_LIMIT_RST;
            lim_reg.vel_limit               <= VEL_LIMIT_RST;
            link_cfg_reg.timeout_ms         <= TIMEOUT_RST;
            link_cfg_reg.lost_report_ms     <= LOST_RPT_RST;
            link_cfg_reg.error_report_ticks <= ERR_RPT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_LOC_LIMIT: lim_reg.loc_limit               <= pwdata[12:0];
                REG_VEL_LIMIT: lim_reg.vel_limit               <= pwdata[12:0];
                REG_TIMEOUT:   link_cfg_reg.timeout_ms         <= pwdata[11:0];
                REG_LOST_RPT:  link_cfg_reg.lost_report_ms     <= pwdata[11:0];
                REG_ERR_RPT:   link_cfg_reg.error_report_ticks <= pwdata[10:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_LOC_LIMIT: prdata = {19'd0, lim_reg.loc_limit};
            REG_VEL_LIMIT: prdata = {19'd0, lim_reg.vel_limit};
            REG_TIMEOUT:   prdata = {20'd0, link_cfg_reg.timeout_ms};
            REG_LOST_RPT:  prdata = {20'd0, link_cfg_reg.lost_report_ms};
            REG_ERR_RPT:   prdata = {21'd0, link_cfg_reg.error_report_ticks};
            default:       prdata = 32'd0;
        endcase
    end

    // input register
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_type_reg <= req.req_type;
            s1_byte_reg <= req.rx_byte;
            s1_ms_reg   <= req.elapsed_ms;
        end
    end

    assign tick.valid = advance && s1_type_reg;
    assign tick.ms    = s1_ms_reg;

    sfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance && !s1_type_reg),
        .rx_byte (s1_byte_reg),
        .lim     (lim_reg),
        .evt     (evt),
        .pv      (pv)
    );

    sfp_link u_link (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .evt    (evt),
        .cfg    (link_cfg_reg),
        .status (status),
        .lost   (lost),
        .err    (err)
    );

    // result register: per-beat flags; values and status come from state, which
    // only moves when this register is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || rsp.ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            done_reg <= evt.done;
            lost_reg <= lost;
            err_reg  <= err;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.frame_done  = done_reg;
    assign rsp.loc_x       = pv[0];
    assign rsp.loc_y       = pv[1];
    assign rsp.loc_z       = pv[2];
    assign rsp.vel_x       = pv[3];
    assign rsp.vel_y       = pv[4];
    assign rsp.vel_z       = pv[5];
    assign rsp.link_status = status;
    assign rsp.lost_alarm  = lost_reg;
    assign rsp.error_alarm = err_reg;

endmodule
